@@ hw/rtl/file_table_block_allocator_core_assert.svh @@
// assertion macros for the file table block allocator
`ifndef FILE_TABLE_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FILE_TABLE_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
// implication checked at every rising clock edge outside reset
`define FTBA_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// next-cycle implication checked outside reset
`define FTBA_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

@@ hw/rtl/ftba_pkg.sv @@
// shared constants and types for the file table block allocator
`default_nettype none
package ftba_pkg;
    localparam int Entries = 16;
    localparam int Blocks = 128;
    localparam int PtrsPerEntry = 8;
    localparam int EntryW = $clog2(Entries);
    localparam int BlockW = $clog2(Blocks);
    localparam int PtrW = $clog2(PtrsPerEntry);
    localparam int CntW = $clog2(Blocks + 1);

    localparam logic [1:0] KIND_CREATE = 2'd0;
    localparam logic [1:0] KIND_DELETE = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_NO_ENTRY = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;
    localparam logic [2:0] ST_TOO_LARGE = 3'd5;

    // block map command from the sequencer
    typedef struct packed {
        logic            start_scan;
        logic            set_bit;
        logic            clr_bit;
        logic [BlockW-1:0] addr;
    } t_map_cmd;

    // block map status back to the sequencer
    typedef struct packed {
        logic            busy;
        logic [CntW-1:0] free_cnt;
        logic            found;
        logic [BlockW-1:0] found_addr;
    } t_map_sts;
endpackage
`default_nettype wire

@@ hw/rtl/ftba_map.sv @@
// used-block map with a one-bit-per-cycle scanning unit
`default_nettype none
module ftba_map
    import ftba_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_map_cmd i_cmd,
    output t_map_sts      o_sts
);
    logic [Blocks-1:0] r_used;
    logic              r_busy;
    logic [CntW-1:0]   r_pos;
    logic [CntW-1:0]   r_free;
    logic              r_found;
    logic [BlockW-1:0] r_faddr;

    // map bits, scan over all blocks one per cycle: counts free, finds first free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used  <= '0;
            r_busy  <= 1'b0;
            r_pos   <= '0;
            r_free  <= '0;
            r_found <= 1'b0;
            r_faddr <= '0;
        end else begin
            if (i_cmd.set_bit) r_used[i_cmd.addr] <= 1'b1;
            if (i_cmd.clr_bit) r_used[i_cmd.addr] <= 1'b0;
            if (i_cmd.start_scan) begin
                r_busy  <= 1'b1;
                r_pos   <= '0;
                r_free  <= '0;
                r_found <= 1'b0;
            end else if (r_busy) begin
                if (!r_used[r_pos[BlockW-1:0]]) begin
                    r_free <= r_free + 1'b1;
                    if (!r_found) begin
                        r_found <= 1'b1;
                        r_faddr <= r_pos[BlockW-1:0];
                    end
                end
                if (r_pos == CntW'(Blocks - 1)) r_busy <= 1'b0;
                r_pos <= r_pos + 1'b1;
            end
        end
    end

    assign o_sts.busy       = r_busy;
    assign o_sts.free_cnt   = r_free;
    assign o_sts.found      = r_found;
    assign o_sts.found_addr = r_faddr;
endmodule
`default_nettype wire

@@ hw/rtl/file_table_block_allocator_core.sv @@
// file table with free-block map, top level and sequencer
// Each command is handled by a sequencer that steps through the file table one entry a cycle
// and through the block map one block a cycle, using a single shared scanning unit. Every
// command first searches the whole table. A lookup that finds its file then reads the
// pointer at its block index, and a delete frees the file's blocks one pointer at a time. A
// create that reaches the block map runs one scan to count free blocks, which ends it for no
// space or zero blocks, and then one fresh scan per claimed block. A result waits in the last
// state while the output register still holds an unaccepted result. A new command is accepted
// only while the sequencer is idle, so one command is in flight at a time, and a result held
// in the output register does not block the next command. No clearing pass.
`default_nettype none
`include "file_table_block_allocator_core_assert.svh"
module file_table_block_allocator_core
    import ftba_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_kind,
    input  wire logic [63:0] i_name_high,
    input  wire logic [63:0] i_name_low,
    input  wire logic [3:0]  i_block_count,
    input  wire logic [3:0]  i_block_index,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_status,
    output logic [6:0]       o_physical_block,
    output logic [3:0]       o_entry_index
);
    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_DECIDE, S_CNT_WAIT, S_ALLOC_SCAN, S_ALLOC_WAIT,
        S_DEL, S_LOOK, S_DONE
    } t_state;

    t_state              r_state;
    logic [1:0]          r_kind;
    logic [63:0]         r_hi, r_lo;
    logic [3:0]          r_cnt, r_idx;
    logic [EntryW:0]     r_e;
    logic                r_hit;
    logic [EntryW-1:0]   r_hit_e;
    logic [3:0]          r_j;
    logic [Entries-1:0]  r_eused;
    logic [63:0]         r_nhi [Entries];
    logic [63:0]         r_nlo [Entries];
    logic [3:0]          r_size [Entries];
    logic [BlockW-1:0]   r_ptr [Entries*PtrsPerEntry];
    logic [BlockW-1:0]   r_prd;
    logic                r_ovalid;
    logic [2:0]          r_ost;
    logic [6:0]          r_opb;
    logic [3:0]          r_oei;
    logic [2:0]          r_out_st;
    logic [6:0]          r_out_pb;
    logic [3:0]          r_out_ei;
    t_map_cmd            w_cmd;
    t_map_sts            w_sts;
    logic [EntryW-1:0]   w_e;
    logic                w_match, w_free_e, w_out_free;

    ftba_map u_map (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts));

    assign w_e        = r_e[EntryW-1:0];
    assign w_match    = r_eused[w_e] && r_nhi[w_e] == r_hi && r_nlo[w_e] == r_lo;
    assign w_free_e   = !r_eused[w_e];
    assign w_out_free = !r_ovalid || !i_stall;
    assign o_stall    = r_state != S_IDLE;

    // map command decode
    always_comb begin
        w_cmd = '0;
        w_cmd.addr = w_sts.found_addr;
        case (r_state)
            S_DECIDE: w_cmd.start_scan = r_kind == KIND_CREATE && r_hit
                                         && r_cnt <= 4'(PtrsPerEntry);
            S_CNT_WAIT: w_cmd.start_scan = !w_sts.busy && w_sts.free_cnt >= CntW'(r_cnt)
                                           && r_cnt != 4'd0;
            S_ALLOC_WAIT: begin
                w_cmd.set_bit = !w_sts.busy;
                w_cmd.start_scan = !w_sts.busy && r_j + 1'b1 < r_cnt;
            end
            S_DEL: begin
                w_cmd.clr_bit = r_j < r_size[r_hit_e];
                w_cmd.addr = r_prd;
            end
            default: ;
        endcase
    end

    // sequencer, table and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_eused  <= '0;
            r_ovalid <= 1'b0;
            r_e <= '0; r_j <= '0; r_hit <= 1'b0; r_hit_e <= '0;
        end else begin
            // output register takes a finished result once it is free
            if (r_state == S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
                r_out_st <= r_ost; r_out_pb <= r_opb; r_out_ei <= r_oei;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            r_prd <= r_ptr[{r_hit_e, r_j[PtrW-1:0]}];
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_kind <= i_kind; r_hi <= i_name_high; r_lo <= i_name_low;
                    r_cnt <= i_block_count; r_idx <= i_block_index;
                    r_e <= '0; r_hit <= 1'b0;
                    // a lookup points at its block index from the start
                    r_j <= (i_kind == KIND_LOOKUP) ? i_block_index : 4'd0;
                    r_state <= S_FIND;
                end
                // one table entry per cycle
                S_FIND: begin
                    if (!r_hit && ((r_kind == KIND_CREATE) ? w_free_e : w_match)) begin
                        r_hit <= 1'b1; r_hit_e <= w_e;
                    end
                    if (r_e == (EntryW+1)'(Entries - 1)) r_state <= S_DECIDE;
                    r_e <= r_e + 1'b1;
                end
                S_DECIDE: begin
                    r_opb <= '0; r_oei <= '0; r_j <= '0;
                    r_state <= S_DONE;
                    case (r_kind)
                        KIND_CREATE:
                            if (r_cnt > 4'(PtrsPerEntry)) r_ost <= ST_TOO_LARGE;
                            else if (!r_hit) r_ost <= ST_NO_ENTRY;
                            else r_state <= S_CNT_WAIT;
                        KIND_DELETE:
                            if (!r_hit) r_ost <= ST_NOT_FOUND;
                            else r_state <= S_DEL;
                        KIND_LOOKUP:
                            if (!r_hit) r_ost <= ST_NOT_FOUND;
                            else begin
                                r_j <= r_idx; r_state <= S_LOOK;
                            end
                        default: r_ost <= ST_NOT_FOUND;
                    endcase
                end
                S_CNT_WAIT: if (!w_sts.busy) begin
                    if (w_sts.free_cnt < CntW'(r_cnt)) begin
                        r_ost <= ST_NO_SPACE; r_state <= S_DONE;
                    end else begin
                        r_eused[r_hit_e] <= 1'b1;
                        r_nhi[r_hit_e] <= r_hi; r_nlo[r_hit_e] <= r_lo;
                        r_size[r_hit_e] <= r_cnt;
                        r_ost <= ST_OK; r_oei <= 4'(r_hit_e);
                        r_state <= (r_cnt == 4'd0) ? S_DONE : S_ALLOC_SCAN;
                    end
                end
                S_ALLOC_SCAN: r_state <= S_ALLOC_WAIT;
                // claim the first free block found by each scan
                S_ALLOC_WAIT: if (!w_sts.busy) begin
                    r_ptr[{r_hit_e, r_j[PtrW-1:0]}] <= w_sts.found_addr;
                    r_j <= r_j + 1'b1;
                    r_state <= (r_j + 1'b1 < r_cnt) ? S_ALLOC_SCAN : S_DONE;
                end
                S_DEL: begin
                    // r_prd holds pointer r_j read in the previous cycle
                    if (r_j >= r_size[r_hit_e] || r_j == 4'(PtrsPerEntry - 1)) begin
                        r_eused[r_hit_e] <= 1'b0;
                        r_ost <= ST_OK; r_oei <= 4'(r_hit_e);
                        r_state <= S_DONE;
                    end else begin
                        r_j <= r_j + 1'b1;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (r_kind == KIND_DELETE) r_state <= S_DEL;
                    else begin
                        r_oei <= 4'(r_hit_e);
                        if (r_idx >= r_size[r_hit_e] || r_idx >= 4'(PtrsPerEntry)) begin
                            r_ost <= ST_BAD_INDEX;
                        end else begin
                            r_ost <= ST_OK; r_opb <= 7'(r_prd);
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: if (w_out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid          = r_ovalid;
    assign o_status         = r_out_st;
    assign o_physical_block = r_out_pb;
    assign o_entry_index    = r_out_ei;

    `FTBA_ASSERT_IMP(a_stall_busy, i_clk, i_rst_n, r_state != S_IDLE, o_stall)
    `FTBA_ASSERT_NXT(a_done_out, i_clk, i_rst_n, r_state == S_DONE && w_out_free, o_valid)
    `FTBA_ASSERT_IMP(a_no_set_clr, i_clk, i_rst_n, w_cmd.set_bit, !w_cmd.clr_bit)
    `FTBA_ASSERT_IMP(a_alloc_found, i_clk, i_rst_n, w_cmd.set_bit, w_sts.found)
endmodule
`default_nettype wire

@@ bench/file_table_block_allocator_core_tb.sv @@
// self-checking testbench for the file table block allocator core
`timescale 1ns / 100ps
`default_nettype none
module file_table_block_allocator_core_tb;
    import ftba_pkg::*;

    localparam int WatchdogLimit = 40000;
    localparam int DrainCycles = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_kind = KIND_CREATE;
    logic [63:0] i_name_high = '0;
    logic [63:0] i_name_low = '0;
    logic [3:0]  i_block_count = '0;
    logic [3:0]  i_block_index = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [2:0]  o_status;
    logic [6:0]  o_physical_block;
    logic [3:0]  o_entry_index;

    typedef struct packed {
        logic [2:0] status;
        logic [6:0] phys;
        logic [3:0] entry;
    } t_reply;

    // predictor state: file table and block map
    logic        tbl_used [Entries];
    logic [63:0] tbl_hi [Entries];
    logic [63:0] tbl_lo [Entries];
    int          tbl_size [Entries];
    logic [6:0]  tbl_ptr [Entries][PtrsPerEntry];
    logic        blk_used [Blocks];

    t_reply reply_queue [$];
    int     fail_count = 0;
    int     idle_cycles = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;

    // pool of names so delete and lookup hit often
    logic [63:0] pool_hi [8];
    logic [63:0] pool_lo [8];

    file_table_block_allocator_core DUT (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        fail_count++;
    endtask

    function automatic int lowest_match(input logic [63:0] hi, input logic [63:0] lo);
        for (int e = 0; e < Entries; e++)
            if (tbl_used[e] && tbl_hi[e] == hi && tbl_lo[e] == lo) return e;
        return -1;
    endfunction

    // compute the reply for one command and update the table
    function automatic t_reply predict_command(input logic [1:0] kind, input logic [63:0] hi,
                                               input logic [63:0] lo, input int cnt,
                                               input int idx);
        t_reply r;
        int e;
        int free_n;
        int taken;
        r = '{status: ST_NOT_FOUND, phys: '0, entry: '0};
        if (kind == KIND_CREATE) begin
            if (cnt > PtrsPerEntry) begin
                r.status = ST_TOO_LARGE;
                return r;
            end
            e = -1;
            for (int k = Entries - 1; k >= 0; k--) if (!tbl_used[k]) e = k;
            if (e < 0) begin
                r.status = ST_NO_ENTRY;
                return r;
            end
            free_n = 0;
            for (int b = 0; b < Blocks; b++) if (!blk_used[b]) free_n++;
            if (free_n < cnt) begin
                r.status = ST_NO_SPACE;
                return r;
            end
            tbl_used[e] = 1'b1;
            tbl_hi[e] = hi;
            tbl_lo[e] = lo;
            tbl_size[e] = cnt;
            taken = 0;
            for (int b = 0; b < Blocks && taken < cnt; b++)
                if (!blk_used[b]) begin
                    blk_used[b] = 1'b1;
                    tbl_ptr[e][taken] = b[6:0];
                    taken++;
                end
            r.status = ST_OK;
            r.entry = e[3:0];
        end else if (kind == KIND_DELETE) begin
            e = lowest_match(hi, lo);
            if (e < 0) return r;
            for (int j = 0; j < tbl_size[e]; j++) blk_used[tbl_ptr[e][j]] = 1'b0;
            tbl_used[e] = 1'b0;
            r.status = ST_OK;
            r.entry = e[3:0];
        end else if (kind == KIND_LOOKUP) begin
            e = lowest_match(hi, lo);
            if (e < 0) return r;
            r.entry = e[3:0];
            if (idx >= tbl_size[e]) r.status = ST_BAD_INDEX;
            else begin
                r.status = ST_OK;
                r.phys = tbl_ptr[e][idx];
            end
        end
        return r;
    endfunction

    // send one command transaction and queue its reply
    task automatic send_command(input logic [1:0] kind, input logic [63:0] hi,
                                input logic [63:0] lo, input logic [3:0] cnt,
                                input logic [3:0] idx);
        i_valid <= 1'b1;
        i_kind <= kind;
        i_name_high <= hi;
        i_name_low <= lo;
        i_block_count <= cnt;
        i_block_index <= idx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        reply_queue.push_back(predict_command(kind, hi, lo, int'(cnt), int'(idx)));
        // sender gap after the transaction
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // receiver stall pattern
    always @(posedge i_clk) i_stall <= ($urandom_range(99) < recv_idle_pct);

    // compare each reply transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (reply_queue.size() == 0) begin
                $display("reply with nothing expected");
                fail_count++;
            end else begin
                want = reply_queue.pop_front();
                if (o_status != want.status)
                    report_mismatch("status", int'(o_status), int'(want.status));
                if (o_physical_block != want.phys)
                    report_mismatch("physical_block", int'(o_physical_block),
                                    int'(want.phys));
                if (o_entry_index != want.entry)
                    report_mismatch("entry_index", int'(o_entry_index), int'(want.entry));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchdogLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed();
        // extreme names, zero and maximal sizes, all statuses but no space
        send_command(KIND_LOOKUP, '1, '1, 4'd0, 4'd0);
        send_command(KIND_DELETE, '0, '0, 4'd0, 4'd0);
        send_command(KIND_CREATE, '1, '1, 4'd15, 4'd15);
        send_command(KIND_CREATE, '1, '1, 4'd9, 4'd0);
        send_command(KIND_CREATE, '0, '0, 4'd0, 4'd0);
        send_command(KIND_LOOKUP, '0, '0, 4'd0, 4'd0);
        send_command(KIND_CREATE, '1, '1, 4'd8, 4'd0);
        send_command(KIND_LOOKUP, '1, '1, 4'd0, 4'd7);
        send_command(KIND_LOOKUP, '1, '1, 4'd0, 4'd8);
        send_command(KIND_LOOKUP, '1, '1, 4'd0, 4'd15);
        send_command(KIND_CREATE, '1, '1, 4'd3, 4'd0);
        send_command(KIND_LOOKUP, '1, '1, 4'd0, 4'd1);
        send_command(2'd3, '1, '1, 4'd15, 4'd15);
        send_command(KIND_DELETE, '1, '1, 4'd0, 4'd0);
        send_command(KIND_LOOKUP, '1, '1, 4'd0, 4'd1);
        // fill every entry, then one more create
        for (int k = 0; k < Entries; k++)
            send_command(KIND_CREATE, 64'h1, 64'(k), 4'd8, 4'd0);
        send_command(KIND_CREATE, 64'h2, 64'h2, 4'd0, 4'd0);
        // then delete them all again
        for (int k = 0; k < Entries; k++)
            send_command(KIND_DELETE, 64'h1, 64'(k), 4'd0, 4'd0);
    endtask

    task automatic test_random(input int n);
        int p;
        int r;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(7);
            r = $urandom_range(99);
            if (r < 5) send_command(2'($urandom), rand64(), rand64(), 4'($urandom), 4'($urandom));
            else if (r < 45)
                send_command(KIND_CREATE, pool_hi[p], pool_lo[p],
                             ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(8)),
                             4'($urandom));
            else if (r < 70)
                send_command(KIND_DELETE, pool_hi[p], pool_lo[p], 4'($urandom), 4'($urandom));
            else
                send_command(KIND_LOOKUP, pool_hi[p], pool_lo[p], 4'($urandom),
                             ($urandom_range(5) == 0) ? 4'($urandom) : 4'($urandom_range(7)));
        end
    endtask

    initial begin
        for (int e = 0; e < Entries; e++) begin
            tbl_used[e] = 1'b0;
            tbl_size[e] = 0;
        end
        for (int b = 0; b < Blocks; b++) blk_used[b] = 1'b0;
        for (int k = 0; k < 8; k++) begin
            pool_hi[k] = rand64();
            pool_lo[k] = rand64();
        end
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_idle_pct = 28;
        recv_idle_pct = 64;
        test_random(520);
        send_idle_pct = 64;
        recv_idle_pct = 28;
        test_random(520);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(520);
        i_valid <= 1'b0;
        while (reply_queue.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (fail_count == 0 && reply_queue.size() == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
